// ===== hw/rtl/zbbd_pkg.sv =====
// shared types, route codes and constants for the banked bus decoder
// no dependencies; zbbd_front, zbbd_back and the top level refer to this package by scoped names
`default_nettype none

package zbbd_pkg;

  // default size of the local ram, mirrored over the low 16 KB
  localparam int unsigned RAM_BYTES = 8192;

  // depths of the request queue and the result queue
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // reciprocal scaling used to fold the mirror offset into the ram
  localparam int unsigned RECIP_SHIFT = 24;

  // width of the offset into the low 16 KB region
  localparam int unsigned OFF_W = 14;

  // route codes of a result
  localparam logic [1:0] ROUTE_LOCAL  = 2'd0;
  localparam logic [1:0] ROUTE_EXT_RD = 2'd1;
  localparam logic [1:0] ROUTE_EXT_WR = 2'd2;
  localparam logic [1:0] ROUTE_ABSORB = 2'd3;

  // fixed read bytes and bank register shape
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;
  localparam logic [7:0] BANK_HI     = 8'h60;
  localparam int unsigned BANK_W     = 9;
  localparam logic [3:0] BANK_LAST   = 4'd8;

  // decoded request as it travels from the front to the back
  typedef struct packed {
    logic [1:0]  route;
    logic        ram_rd;
    logic        ram_wr;
    logic [7:0]  read_data;
    logic [23:0] ext_address;
    logic [7:0]  ext_data;
    logic [7:0]  wr_data;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]  route;
    logic [7:0]  read_data;
    logic [23:0] ext_address;
    logic [7:0]  ext_data;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zbbd_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module zbbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read first port, read data registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zbbd_fifo.sv =====
// small synchronous queue with full, empty and fill count
// no dependencies
`default_nettype none

module zbbd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           data_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic      [Width-1:0]           data_o,
  output logic                            empty_o,
  output logic      [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zbbd_front.sv =====
// front part: accepts bus requests, decodes the memory map, keeps the bank
// register and folds the mirror offset into a ram index; uses zbbd_pkg
`default_nettype none

module zbbd_front #(
  parameter int unsigned RamBytes = zbbd_pkg::RAM_BYTES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind_i,
  input  wire logic [15:0]                 address_i,
  input  wire logic [7:0]                  write_data_i,
  output logic                             cmd_push_o,
  output zbbd_pkg::cmd_t                   cmd_o,
  output logic      [$clog2(RamBytes)-1:0] cmd_idx_o,
  input  wire logic                        cmd_full_i
);

  localparam int unsigned AddrW  = $clog2(RamBytes);
  localparam int unsigned OffW   = zbbd_pkg::OFF_W;
  localparam int unsigned NW     = OffW + 1;
  localparam int unsigned Recip  = (1 << zbbd_pkg::RECIP_SHIFT) / RamBytes;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW  = OffW + RecipW;
  localparam int unsigned QW     = ProdW - zbbd_pkg::RECIP_SHIFT;
  localparam logic [NW-1:0] NConst = NW'(RamBytes);

  zbbd_pkg::cmd_t cmd_d;
  zbbd_pkg::cmd_t s1_cmd_q, s2_cmd_q;
  logic           s1_valid_q, s2_valid_q;
  logic [OffW-1:0] off_d, s1_off_q, s2_off_q;
  logic [ProdW-1:0] prod;
  logic [QW-1:0]  s1_quot_q;
  logic [NW-1:0]  qn_d, s2_qn_q;
  logic [NW-1:0]  rem_raw, rem;

  logic [zbbd_pkg::BANK_W-1:0] acc_q, acc_d;
  logic [3:0]                  bit_cnt_q, bit_cnt_d;
  logic [zbbd_pkg::BANK_W-1:0] page_q, page_d;

  logic stall, accept, is_bank;

  // whole pipeline holds while the last stage cannot hand over
  assign stall  = s2_valid_q && cmd_full_i;
  assign full   = stall;
  assign accept = push && !stall;

  // memory map decode
  always_comb begin
    cmd_d             = '0;
    cmd_d.wr_data     = write_data_i;
    is_bank           = 1'b0;
    if (!kind_i) begin
      if (address_i[15:14] == 2'b00) begin
        cmd_d.route  = zbbd_pkg::ROUTE_LOCAL;
        cmd_d.ram_rd = 1'b1;
      end else if (address_i[15]) begin
        cmd_d.route       = zbbd_pkg::ROUTE_EXT_RD;
        cmd_d.ext_address = {page_q, address_i[14:0]};
      end else if (!address_i[13]) begin
        cmd_d.route     = zbbd_pkg::ROUTE_LOCAL;
        cmd_d.read_data = (address_i[1:0] == 2'b00) ? zbbd_pkg::BYTE_ZERO
                                                     : zbbd_pkg::BYTE_ONES;
      end else begin
        cmd_d.route     = zbbd_pkg::ROUTE_LOCAL;
        cmd_d.read_data = zbbd_pkg::BYTE_ONES;
      end
    end else begin
      if (address_i[15:14] == 2'b00) begin
        cmd_d.route  = zbbd_pkg::ROUTE_ABSORB;
        cmd_d.ram_wr = 1'b1;
      end else if (address_i[15]) begin
        cmd_d.route       = zbbd_pkg::ROUTE_EXT_WR;
        cmd_d.ext_address = {page_q, address_i[14:0]};
        cmd_d.ext_data    = write_data_i;
      end else begin
        cmd_d.route = zbbd_pkg::ROUTE_ABSORB;
        is_bank     = (address_i[15:8] == zbbd_pkg::BANK_HI);
      end
    end
  end

  // bank bit shifter, lsb first, page loads on the ninth bit
  always_comb begin
    acc_d     = acc_q;
    bit_cnt_d = bit_cnt_q;
    page_d    = page_q;
    if (accept && kind_i && is_bank) begin
      if (bit_cnt_q == zbbd_pkg::BANK_LAST) begin
        page_d    = acc_q | (zbbd_pkg::BANK_W'(write_data_i[0]) << bit_cnt_q);
        acc_d     = '0;
        bit_cnt_d = '0;
      end else begin
        acc_d     = acc_q | (zbbd_pkg::BANK_W'(write_data_i[0]) << bit_cnt_q);
        bit_cnt_d = bit_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      bit_cnt_q <= '0;
      page_q    <= '0;
    end else begin
      acc_q     <= acc_d;
      bit_cnt_q <= bit_cnt_d;
      page_q    <= page_d;
    end
  end

  // mirror fold: quotient estimate by reciprocal, then product, then one correction
  assign off_d   = address_i[OffW-1:0];
  assign prod    = ProdW'(off_d) * ProdW'(Recip);
  assign qn_d    = NW'(NW'(s1_quot_q) * NConst);
  assign rem_raw = NW'(s2_off_q) - s2_qn_q;
  assign rem     = (rem_raw >= NConst) ? rem_raw - NConst : rem_raw;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_cmd_q  <= cmd_d;
      s1_off_q  <= off_d;
      s1_quot_q <= prod[zbbd_pkg::RECIP_SHIFT +: QW];
      s2_cmd_q  <= s1_cmd_q;
      s2_off_q  <= s1_off_q;
      s2_qn_q   <= qn_d;
    end
  end

  assign cmd_push_o = s2_valid_q && !stall;
  assign cmd_o      = s2_cmd_q;
  assign cmd_idx_o  = rem[AddrW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/zbbd_back.sv =====
// back part: carries out ram requests and queues the results
// uses zbbd_pkg, zbbd_ram and zbbd_fifo
`default_nettype none

module zbbd_back #(
  parameter int unsigned RamBytes = zbbd_pkg::RAM_BYTES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_empty_i,
  input  wire zbbd_pkg::cmd_t              cmd_i,
  input  wire logic [$clog2(RamBytes)-1:0] cmd_idx_i,
  output logic                             cmd_pop_o,
  input  wire logic                        pop,
  output logic                             empty,
  output zbbd_pkg::res_t                   res_o
);

  localparam int unsigned AddrW = $clog2(RamBytes);
  localparam int unsigned CntW  = $clog2(zbbd_pkg::OUT_DEPTH + 1);
  localparam int unsigned ResW  = $bits(zbbd_pkg::res_t);

  logic            issue;
  logic            rsp_valid_q;
  logic            rsp_sel_q;
  zbbd_pkg::res_t  rsp_q, rsp_push;
  logic [7:0]      ram_rdata;
  logic [CntW-1:0] out_cnt;
  logic [CntW:0]   used;
  logic            out_full;
  logic [ResW-1:0] out_data;

  // a request goes only when its result is sure of a place
  assign used      = (CntW + 1)'(out_cnt) + (CntW + 1)'(rsp_valid_q);
  assign issue     = !cmd_empty_i && (used < (CntW + 1)'(zbbd_pkg::OUT_DEPTH));
  assign cmd_pop_o = issue;

  zbbd_ram #(
    .Width(8),
    .Depth(RamBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (issue && (cmd_i.ram_rd || cmd_i.ram_wr)),
    .we_i   (issue && cmd_i.ram_wr),
    .addr_i (cmd_idx_i[AddrW-1:0]),
    .wdata_i(cmd_i.wr_data),
    .rdata_o(ram_rdata)
  );

  // response stage lines up with the ram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rsp_sel_q         <= cmd_i.ram_rd;
      rsp_q.route       <= cmd_i.route;
      rsp_q.read_data   <= cmd_i.read_data;
      rsp_q.ext_address <= cmd_i.ext_address;
      rsp_q.ext_data    <= cmd_i.ext_data;
    end
  end

  // merge ram data into the result
  always_comb begin
    rsp_push = rsp_q;
    if (rsp_sel_q) begin
      rsp_push.read_data = ram_rdata;
    end
  end

  zbbd_fifo #(
    .Width(ResW),
    .Depth(zbbd_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_valid_q),
    .data_i (rsp_push),
    .full_o (out_full),
    .pop_i  (pop && !out_full | pop),
    .data_o (out_data),
    .empty_o(empty),
    .count_o(out_cnt)
  );

  assign res_o = zbbd_pkg::res_t'(out_data);

endmodule

`default_nettype wire

// ===== hw/rtl/z80_banked_bus_decoder.sv =====
// top level of the banked bus decoder: front, request queue, back
// uses zbbd_pkg, zbbd_front, zbbd_fifo, zbbd_back
//
//  channel  | handshake      | payload
//  ---------+----------------+---------------------------------------------
//  access   | push / full    | kind_i, address_i, write_data_i
//  result   | empty / pop    | route_o, read_data_o, ext_address_o, ext_data_o
//
// one access can be taken each cycle while full is low; a result reaches the ports
// once it has passed the two fold stages, the request queue, the ram read and
// the result queue
// reset clears the bank register, its bit count and all queues; ram contents
// are not cleared and there is no clearing pass
// full rises only when the request queue is full and the front has a request
// waiting; the back stops when the result queue holds no free place
`default_nettype none

module z80_banked_bus_decoder #(
  parameter int unsigned RamBytes = zbbd_pkg::RAM_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       route_o,
  output logic [7:0]       read_data_o,
  output logic [23:0]      ext_address_o,
  output logic [7:0]       ext_data_o
);

  localparam int unsigned AddrW = $clog2(RamBytes);
  localparam int unsigned CmdW  = $bits(zbbd_pkg::cmd_t) + AddrW;

  logic                  cmd_push, cmd_full, cmd_empty, cmd_pop;
  zbbd_pkg::cmd_t        cmd_in, cmd_out;
  logic [AddrW-1:0]      idx_in, idx_out;
  logic [CmdW-1:0]       q_out;
  logic [$clog2(zbbd_pkg::CMD_DEPTH+1)-1:0] cmd_cnt;
  zbbd_pkg::res_t        res;

  zbbd_front #(
    .RamBytes(RamBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_idx_o   (idx_in),
    .cmd_full_i  (cmd_full)
  );

  // request queue between front and back
  zbbd_fifo #(
    .Width(CmdW),
    .Depth(zbbd_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i ({cmd_in, idx_in}),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (q_out),
    .empty_o(cmd_empty),
    .count_o(cmd_cnt)
  );

  assign cmd_out = zbbd_pkg::cmd_t'(q_out[CmdW-1:AddrW]);
  assign idx_out = q_out[AddrW-1:0];

  zbbd_back #(
    .RamBytes(RamBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty || (cmd_cnt == '0)),
    .cmd_i      (cmd_out),
    .cmd_idx_i  (idx_out),
    .cmd_pop_o  (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign route_o       = res.route;
  assign read_data_o   = res.read_data;
  assign ext_address_o = res.ext_address;
  assign ext_data_o    = res.ext_data;

endmodule

`default_nettype wire
